[rtl/tdat_pkg.sv]
// Shared types and constants for the touch-delayed alarm trigger.
package tdat_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned DebW    = 16;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] TriggerDelayReset = TimeW'(2000);
  localparam logic [DebW-1:0]  DebounceReset     = DebW'(100);
  localparam logic [TimeW-1:0] ActiveReset       = TimeW'(5000);

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRIGGER_DELAY = 2'd0,
    REG_DEBOUNCE      = 2'd1,
    REG_ACTIVE        = 2'd2
  } cfg_reg_t;

  // Flags shown after one poll's update.
  typedef struct packed {
    logic triggered;
    logic touched;
    logic waiting;
  } tdat_status_t;

  // Timing settings handed to the core.
  typedef struct packed {
    logic [TimeW-1:0] trigger_delay_ms;
    logic [DebW-1:0]  debounce_ms;
    logic [TimeW-1:0] active_ms;
  } tdat_cfg_t;

endpackage

[rtl/touch_delayed_alarm_trigger_top.sv]
// Touch-delayed alarm trigger: top level with config, core and result register.
// The result of a transferred poll is registered and shown in the cycle after the transfer.
// One poll per cycle while the sink is ready; the core state updates in a single pass and
//   the result register frees in the same cycle it is taken downstream.
// Reset (rst, synchronous, active high): registers back to 2000/100/5000 ms,
//   all state zero, no result pending.
module touch_delayed_alarm_trigger_top
  import tdat_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  // poll input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TimeW-1:0]   now_ms,
  input  logic               touch_level,
  input  logic               clear_request,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               relay_drive,
  output logic               alarm_drive,
  output logic               touched_flag,
  output logic               waiting_flag
);

  tdat_cfg_t    cfg;
  tdat_status_t status_next;
  tdat_status_t result;
  logic         in_xfer;

  // A new poll is taken whenever the result register is empty or is being
  // drained this cycle, so full rate holds under a continuously ready sink.
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  tdat_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Core updates its state only on a transfer; status_next is the state
  // after edge detect, delay check, active check and clear, in that order.
  tdat_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (in_xfer),
    .cfg           (cfg),
    .now_ms        (now_ms),
    .touch_level   (touch_level),
    .clear_request (clear_request),
    .status_next   (status_next)
  );

  // Result register: loads on each transfer, holds while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) result <= status_next;
  end

  // relay and alarm are driven together from the triggered state
  assign relay_drive  = result.triggered;
  assign alarm_drive  = result.triggered;
  assign touched_flag = result.touched;
  assign waiting_flag = result.waiting;

  // Waiting and triggered never overlap in a shown result.
  a_wait_trig_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(relay_drive && waiting_flag))
    else $error("waiting and triggered both set");

  // Any active phase implies an accepted touch still on record.
  a_active_touched: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (relay_drive || waiting_flag)) |-> touched_flag)
    else $error("active phase without touched flag");

  // A stalled result must not be overwritten by a new poll.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while result stalled");

  // Result register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

endmodule

[rtl/tdat_cfg_regs.sv]
// Configuration register file of the touch-delayed alarm trigger.
module tdat_cfg_regs
  import tdat_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output tdat_cfg_t          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_delay_ms <= TriggerDelayReset;
      cfg.debounce_ms      <= DebounceReset;
      cfg.active_ms        <= ActiveReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TRIGGER_DELAY: cfg.trigger_delay_ms <= cfg_data[TimeW-1:0];
        REG_DEBOUNCE:      cfg.debounce_ms      <= cfg_data[DebW-1:0];
        REG_ACTIVE:        cfg.active_ms        <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/tdat_core.sv]
// Per-poll state update: edge debounce, trigger delay, active period, clear.
module tdat_core
  import tdat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tdat_cfg_t        cfg,
  input  logic [TimeW-1:0] now_ms,
  input  logic             touch_level,
  input  logic             clear_request,
  output tdat_status_t     status_next
);

  logic             prev_touch;
  logic [TimeW-1:0] last_edge_time;
  logic [TimeW-1:0] wait_start_time;
  logic [TimeW-1:0] active_start_time;
  logic             waiting;
  logic             triggered;
  logic             touched;

  logic             edge_ok;
  logic             start_wait;
  logic             waiting_a;
  logic [TimeW-1:0] wait_start_a;
  logic             fire;
  logic             triggered_a;
  logic [TimeW-1:0] active_start_a;
  logic             expire;
  logic             go_idle;
  logic [TimeW-1:0] since_edge;
  logic [TimeW-1:0] since_wait;
  logic [TimeW-1:0] since_active;

  always_comb begin
    since_edge     = now_ms - last_edge_time;
    edge_ok        = touch_level && !prev_touch &&
                     (since_edge > {{(TimeW-DebW){1'b0}}, cfg.debounce_ms});
    start_wait     = edge_ok && !waiting && !triggered;
    waiting_a      = waiting || start_wait;
    wait_start_a   = start_wait ? now_ms : wait_start_time;
    since_wait     = now_ms - wait_start_a;
    fire           = waiting_a && (since_wait >= cfg.trigger_delay_ms);
    triggered_a    = triggered || fire;
    active_start_a = fire ? now_ms : active_start_time;
    since_active   = now_ms - active_start_a;
    expire         = triggered_a && (since_active >= cfg.active_ms);
    go_idle        = expire || clear_request;

    status_next.waiting   = waiting_a && !fire && !go_idle;
    status_next.triggered = triggered_a && !go_idle;
    status_next.touched   = (touched || edge_ok) && !go_idle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_touch        <= 1'b0;
      last_edge_time    <= '0;
      wait_start_time   <= '0;
      active_start_time <= '0;
      waiting           <= 1'b0;
      triggered         <= 1'b0;
      touched           <= 1'b0;
    end else if (step) begin
      prev_touch        <= touch_level;
      if (edge_ok) last_edge_time <= now_ms;
      wait_start_time   <= wait_start_a;
      active_start_time <= active_start_a;
      waiting           <= status_next.waiting;
      triggered         <= status_next.triggered;
      touched           <= status_next.touched;
    end
  end

endmodule
